[rtl/core/npm_pkg.sv]
package npm_pkg;

	// Table size and the widths that follow from it.
	localparam int MAX_POINTS = 1024;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	// Fixed field widths.
	localparam int COORD_W = 16;
	localparam int REQ_W = 2;
	localparam int MATCH_W = 10;
	localparam int RADIUS_W = 34;
	localparam int SQ_W = 2 * COORD_W;
	localparam int DIST_W = SQ_W + 1;
	localparam int WORD_W = 2 * COORD_W;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;
	localparam logic REG_RADIUS = 1'b0;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		OP_APPEND,
		OP_QUERY
	} op_kind_t;

	// One queued operation; arg is the write address of an append or the
	// number of stored points seen by a query.
	typedef struct packed {
		op_kind_t kind;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [CNT_W-1:0] arg;
	} op_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DRAIN,
		B_DONE
	} back_state_t;

	// Magnitude of the difference of two coordinates.
	function automatic logic [COORD_W-1:0] abs_diff(logic [COORD_W-1:0] a,
		logic [COORD_W-1:0] b);
		logic [COORD_W:0] d;
		logic [COORD_W:0] n;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		n = -d;
		return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
	endfunction

endpackage

[rtl/core/npm_ram.sv]
module npm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/npm_queue.sv]
module npm_queue (
	input logic clk,
	input logic arst_n,
	input logic enq_valid,
	input npm_pkg::op_t enq_op,
	output logic full,
	output logic deq_valid,
	output npm_pkg::op_t deq_op,
	input logic deq_ready
);
	import npm_pkg::*;

	op_t entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign full = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign deq_valid = (count_q != '0);
	assign deq_op = entries_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (enq_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq_ready) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq_valid && !deq_ready) begin
				count_q <= count_q + 1'b1;
			end else if (!enq_valid && deq_ready) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (enq_valid) begin
			entries_q[wr_ptr_q] <= enq_op;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		enq_valid |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		deq_ready |-> deq_valid)
		else $error("queue read while empty");
`endif

endmodule

[rtl/core/npm_front.sv]
module npm_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [npm_pkg::REQ_W-1:0] req_type,
	input logic signed [npm_pkg::COORD_W-1:0] point_x,
	input logic signed [npm_pkg::COORD_W-1:0] point_y,
	input logic queue_full,
	output logic full,
	output logic enq_valid,
	output npm_pkg::op_t enq_op
);
	import npm_pkg::*;

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_POINTS);

	logic [CNT_W-1:0] count_q;
	logic accept;

	assign full = queue_full;
	assign accept = push && !queue_full;

	// Classify the item: clears are handled here, appends to a full table and
	// unused codes are dropped, the rest go to the back.
	always_comb begin
		enq_valid = 1'b0;
		enq_op.kind = OP_QUERY;
		enq_op.x = point_x;
		enq_op.y = point_y;
		enq_op.arg = count_q;
		case (req_type)
			REQ_APPEND: begin
				enq_op.kind = OP_APPEND;
				enq_valid = accept && (count_q != MAX_COUNT);
			end
			REQ_QUERY: begin
				enq_valid = accept;
			end
			default: begin
				enq_valid = 1'b0;
			end
		endcase
	end

	// Number of stored points as seen by later items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (req_type == REQ_CLEAR) begin
				count_q <= '0;
			end else if (req_type == REQ_APPEND && count_q != MAX_COUNT) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

[rtl/core/npm_back.sv]
module npm_back (
	input logic clk,
	input logic arst_n,
	input logic [npm_pkg::RADIUS_W-1:0] radius_squared,
	input logic deq_valid,
	input npm_pkg::op_t deq_op,
	output logic deq_ready,
	output logic empty,
	input logic pop,
	output logic matched,
	output logic [npm_pkg::MATCH_W-1:0] match_index
);
	import npm_pkg::*;

	back_state_t state_q, state_d;

	logic ram_we;
	logic ram_re;
	logic start;
	logic load_out;
	logic [WORD_W-1:0] rdata_s1;

	logic signed [COORD_W-1:0] qx_q;
	logic signed [COORD_W-1:0] qy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] j_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [COORD_W-1:0] adx_s2, ady_s2;
	logic [SQ_W-1:0] sqx_s3, sqy_s3;
	logic [DIST_W-1:0] d2_s4;

	logic found_q;
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic hit;

	logic out_valid_q;
	logic matched_q;
	logic [MATCH_W-1:0] match_index_q;

	// Point memory, x in the upper half of each word.
	npm_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(deq_op.arg[IDX_W-1:0]),
		.wdata({deq_op.x, deq_op.y}),
		.re(ram_re),
		.raddr(j_q[IDX_W-1:0]),
		.rdata(rdata_s1)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control.
	always_comb begin
		state_d = state_q;
		deq_ready = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		start = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (deq_valid) begin
					deq_ready = 1'b1;
					if (deq_op.kind == OP_APPEND) begin
						ram_we = 1'b1;
					end else begin
						start = 1'b1;
						state_d = (deq_op.arg == '0) ? B_DONE : B_SCAN;
					end
				end
			end
			B_SCAN: begin
				ram_re = 1'b1;
				if (j_q == cnt_q - 1'b1) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: begin
				if (!(v1_s1 || v2_s2 || v3_s3 || v4_s4)) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			v1_s1 <= ram_re;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
		end
	end

	// A stored point is a candidate when strictly inside the radius and
	// strictly nearer than the best so far, so ties keep the lowest index.
	assign hit = ({1'b0, d2_s4} < radius_squared) && (!found_q || d2_s4 < best_q);

	// Query registers, distance pipeline and running best.
	always_ff @(posedge clk) begin
		if (start) begin
			qx_q <= deq_op.x;
			qy_q <= deq_op.y;
			cnt_q <= deq_op.arg;
			j_q <= '0;
			best_q <= '0;
			best_idx_q <= '0;
		end else if (ram_re) begin
			j_q <= j_q + 1'b1;
		end
		idx_s1 <= j_q[IDX_W-1:0];
		adx_s2 <= abs_diff(qx_q, rdata_s1[WORD_W-1:COORD_W]);
		ady_s2 <= abs_diff(qy_q, rdata_s1[COORD_W-1:0]);
		idx_s2 <= idx_s1;
		sqx_s3 <= adx_s2 * adx_s2;
		sqy_s3 <= ady_s2 * ady_s2;
		idx_s3 <= idx_s2;
		d2_s4 <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
		idx_s4 <= idx_s3;
		if (v4_s4 && hit) begin
			best_q <= d2_s4;
			best_idx_q <= idx_s4;
		end
		if (load_out) begin
			matched_q <= found_q;
			match_index_q <= MATCH_W'(best_idx_q);
		end
	end

	// Match flag of the running best.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (start) begin
			found_q <= 1'b0;
		end else if (v4_s4 && hit) begin
			found_q <= 1'b1;
		end
	end

	// Result register toward the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty = !out_valid_q;
	assign matched = matched_q;
	assign match_index = match_index_q;

`ifndef SYNTHESIS
	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("point memory written and read in one cycle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SCAN) |-> (j_q < cnt_q))
		else $error("scan index beyond stored count");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(match_index_q)
		&& $stable(matched_q)))
		else $error("waiting result changed before it was taken");
`endif

endmodule

[rtl/core/nearest_point_match_in_radius.sv]
// Items are accepted while the queue has room; an append passes through the queue and
// is written to the point memory when an idle back end takes it from the queue.
// A query taken by an idle back end scans the stored points through the single memory
// read port, one stored point per cycle, then drains the distance pipeline and waits
// until the result register is free; the next query starts when this one is done.
// Reset clears the stored count, radius, queue and sequencer, not the point memory.
module nearest_point_match_in_radius (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [npm_pkg::REQ_W-1:0] req_type,
	input logic signed [npm_pkg::COORD_W-1:0] point_x,
	input logic signed [npm_pkg::COORD_W-1:0] point_y,
	output logic empty,
	input logic pop,
	output logic matched,
	output logic [npm_pkg::MATCH_W-1:0] match_index,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [npm_pkg::PADDR_W-1:0] paddr,
	input logic [npm_pkg::PDATA_W-1:0] pwdata,
	output logic [npm_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	import npm_pkg::*;

	logic [RADIUS_W-1:0] radius_q;
	logic queue_full;
	logic enq_valid;
	op_t enq_op;
	logic deq_valid;
	op_t deq_op;
	logic deq_ready;
	logic reg_sel;

	// Configuration register; the register is chosen by the 8-byte slot.
	assign pready = 1'b1;
	assign reg_sel = paddr[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_RADIUS) begin
			radius_q <= pwdata[RADIUS_W-1:0];
		end
	end

	assign prdata = (reg_sel == REG_RADIUS) ? PDATA_W'(radius_q) : '0;

	// Front end: accepts and classifies items.
	npm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.req_type(req_type),
		.point_x(point_x),
		.point_y(point_y),
		.queue_full(queue_full),
		.full(full),
		.enq_valid(enq_valid),
		.enq_op(enq_op)
	);

	// Operation queue between the two halves.
	npm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.enq_valid(enq_valid),
		.enq_op(enq_op),
		.full(queue_full),
		.deq_valid(deq_valid),
		.deq_op(deq_op),
		.deq_ready(deq_ready)
	);

	// Back end: memory writes, scans and results.
	npm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.radius_squared(radius_q),
		.deq_valid(deq_valid),
		.deq_op(deq_op),
		.deq_ready(deq_ready),
		.empty(empty),
		.pop(pop),
		.matched(matched),
		.match_index(match_index)
	);

endmodule

[verif/npm_checker.sv]
`timescale 1ns / 100ps

module npm_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic [npm_pkg::REQ_W-1:0] req_type,
	input logic signed [npm_pkg::COORD_W-1:0] point_x,
	input logic signed [npm_pkg::COORD_W-1:0] point_y,
	input logic empty,
	input logic pop,
	input logic matched,
	input logic [npm_pkg::MATCH_W-1:0] match_index,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [npm_pkg::PADDR_W-1:0] paddr,
	input logic [npm_pkg::PDATA_W-1:0] pwdata,
	output int mismatches,
	output int outstanding
);
	import npm_pkg::*;

	// One query answer as it appears on the result ports.
	typedef struct packed {
		logic matched;
		logic [MATCH_W-1:0] index;
	} match_t;

	// Shadow copy of the point table and the radius register.
	logic signed [COORD_W-1:0] table_x [MAX_POINTS];
	logic signed [COORD_W-1:0] table_y [MAX_POINTS];
	logic [CNT_W-1:0] table_count = '0;
	logic [RADIUS_W-1:0] radius = '0;

	// Answers predicted for accepted queries, oldest first.
	match_t expected_matches[$];
	int fail_count = 0;

	// Absolute difference of two signed coordinates, exact in 16 bits.
	function automatic logic [COORD_W-1:0] coord_gap(input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
	endfunction

	// Scan the stored points and pick the closest one strictly inside the radius.
	// A later point only replaces the best one when it is strictly closer, so ties
	// keep the lowest index.
	function automatic match_t nearest_in_radius(input logic signed [COORD_W-1:0] qx,
		input logic signed [COORD_W-1:0] qy);
		match_t best;
		logic [DIST_W-1:0] best_dist;
		logic [DIST_W-1:0] sq_dist;
		logic [COORD_W-1:0] gx;
		logic [COORD_W-1:0] gy;
		logic [SQ_W-1:0] sx;
		logic [SQ_W-1:0] sy;
		best = '0;
		best_dist = '0;
		for (int j = 0; j < int'(table_count); j++) begin
			gx = coord_gap(qx, table_x[j]);
			gy = coord_gap(qy, table_y[j]);
			sx = gx * gx;
			sy = gy * gy;
			sq_dist = DIST_W'(sx) + DIST_W'(sy);
			if (RADIUS_W'(sq_dist) < radius && (!best.matched || sq_dist < best_dist)) begin
				best.matched = 1'b1;
				best.index = MATCH_W'(j);
				best_dist = sq_dist;
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		match_t got;
		match_t want;
		if (!arst_n) begin
			radius = '0;
			table_count = '0;
			expected_matches.delete();
		end else begin
			// Register writes on the configuration port.
			if (psel && penable && pwrite && pready &&
				paddr == PADDR_W'({REG_RADIUS, 3'b000})) begin
				radius = pwdata[RADIUS_W-1:0];
			end

			// Accepted request items update the table or predict an answer.
			if (push && !full) begin
				case (req_type)
					REQ_CLEAR: table_count = '0;
					REQ_APPEND: begin
						if (table_count < MAX_POINTS) begin
							table_x[table_count[IDX_W-1:0]] = point_x;
							table_y[table_count[IDX_W-1:0]] = point_y;
							table_count = table_count + 1'b1;
						end
					end
					REQ_QUERY: expected_matches = {expected_matches,
						nearest_in_radius(point_x, point_y)};
					default: ;
				endcase
			end

			// Accepted answers are compared with the oldest prediction.
			if (pop && !empty) begin
				got.matched = matched;
				got.index = match_index;
				if (expected_matches.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Unexpected answer: matched=%0b index=%0d", got.matched,
							got.index);
				end else begin
					want = expected_matches.pop_front();
					if (got.matched !== want.matched || got.index !== want.index) begin
						fail_count++;
						if (fail_count <= 10)
							$display("Answer mismatch: expected matched=%0b index=%0d,",
								want.matched, want.index,
								" got matched=%0b index=%0d", got.matched, got.index);
					end
				end
			end
		end
		mismatches <= fail_count;
		outstanding <= expected_matches.size();
	end

endmodule

[verif/nearest_point_match_in_radius_tb.sv]
`timescale 1ns / 100ps

module nearest_point_match_in_radius_tb;
	import npm_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
	localparam int RANDOM_ITEMS = 580;
	localparam int SETTLE_CYCLES = 24;
	localparam int TAIL_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 8000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [REQ_W-1:0] req_type = REQ_CLEAR;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic empty;
	logic pop = 1'b0;
	logic matched;
	logic [MATCH_W-1:0] match_index;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	int mismatches;
	int outstanding;

	// Points the stimulus has stored, kept only to aim queries at them.
	logic signed [COORD_W-1:0] known_x [MAX_POINTS];
	logic signed [COORD_W-1:0] known_y [MAX_POINTS];
	int known_count = 0;
	int counted_items = 0;
	int burst_left = 0;
	int pop_mode = 0;
	int pop_left = 0;

	nearest_point_match_in_radius i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.point_x(point_x),
		.point_y(point_y),
		.empty(empty),
		.pop(pop),
		.matched(matched),
		.match_index(match_index),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	npm_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.point_x(point_x),
		.point_y(point_y),
		.empty(empty),
		.pop(pop),
		.matched(matched),
		.match_index(match_index),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Result side: long runs of steady popping, coin-flip popping and heavy stalls.
	always @(posedge clk) begin
		if (pop_left == 0) begin
			pop_mode <= $urandom_range(0, 2);
			pop_left <= $urandom_range(10, 150);
		end else begin
			pop_left <= pop_left - 1;
		end
		case (pop_mode)
			0: pop <= arst_n;
			1: pop <= arst_n && ($urandom_range(0, 1) == 1);
			default: pop <= arst_n && ($urandom_range(0, 7) == 0);
		endcase
	end

	// Ends the run when nothing moves on any port for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
		return COORD_W'(v < -32768 ? -32768 : (v > 32767 ? 32767 : v));
	endfunction

	function automatic logic signed [COORD_W-1:0] near_coord(input int center, input int span);
		return clamp_coord(center + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// Sends one request item in bursts separated by random gaps.
	task automatic send_item(input logic [REQ_W-1:0] req,
		input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 10);
		end
		burst_left--;
		push <= 1'b1;
		req_type <= req;
		point_x <= x;
		point_y <= y;
		do @(posedge clk); while (full !== 1'b0);

		// Track what was stored so queries can hit stored points exactly.
		if (req == REQ_CLEAR) begin
			known_count = 0;
		end else if (req == REQ_APPEND && known_count < MAX_POINTS) begin
			known_x[known_count] = x;
			known_y[known_count] = y;
			known_count++;
		end
		if (req != REQ_UNUSED)
			counted_items++;
	endtask

	// Writes the radius once the block has gone quiet. The count of open queries is
	// registered in the checker, so the task waits for it to include the item accepted last.
	task automatic write_radius(input logic [RADIUS_W-1:0] value);
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({REG_RADIUS, 3'b000});
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Fills the table past its capacity and queries the ends of it.
	task automatic fill_table();
		logic signed [COORD_W-1:0] lost_x;
		logic signed [COORD_W-1:0] lost_y;
		lost_x = '0;
		lost_y = '0;
		write_radius(RADIUS_W'(1) << 22);
		send_item(REQ_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
		for (int i = 0; i < MAX_POINTS + 6; i++) begin
			lost_x = COORD_W'($urandom);
			lost_y = COORD_W'($urandom);
			send_item(REQ_APPEND, lost_x, lost_y);
		end
		send_item(REQ_QUERY, known_x[MAX_POINTS-1], known_y[MAX_POINTS-1]);
		send_item(REQ_QUERY, known_x[0], known_y[0]);
		send_item(REQ_QUERY, lost_x, lost_y);
		send_item(REQ_QUERY, COORD_W'($urandom), COORD_W'($urandom));
		write_radius(RADIUS_MAX);
		send_item(REQ_QUERY, COORD_W'($urandom), COORD_W'($urandom));
		send_item(REQ_CLEAR, '0, '0);
	endtask

	// One random phase: a radius, a table clustered around a center, then a mix
	// of mostly queries with appends, clears and unused codes sprinkled in.
	task automatic random_phase();
		int scale;
		int span;
		int cx;
		int cy;
		int fill;
		int ops;
		int pick;
		int k;
		logic [63:0] raw;
		logic [RADIUS_W-1:0] rad;
		scale = $urandom_range(0, 15);
		span = 1 << scale;
		raw = {$urandom, $urandom};
		pick = $urandom_range(0, 11);
		if (pick == 0)
			rad = '0;
		else if (pick == 1)
			rad = RADIUS_MAX;
		else
			rad = raw[RADIUS_W-1:0] >> (RADIUS_W - 2 * scale - 2);
		write_radius(rad);
		cx = int'($urandom_range(0, 65535)) - 32768;
		cy = int'($urandom_range(0, 65535)) - 32768;
		if ($urandom_range(0, 4) != 0 || known_count > 200)
			send_item(REQ_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
		fill = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160) : $urandom_range(0, 24);
		for (int i = 0; i < fill; i++) begin
			if (known_count > 0 && $urandom_range(0, 5) == 0) begin
				k = $urandom_range(0, known_count - 1);
				send_item(REQ_APPEND, known_x[k], known_y[k]);
			end else begin
				send_item(REQ_APPEND, near_coord(cx, span), near_coord(cy, span));
			end
		end
		ops = $urandom_range(10, 40);
		for (int i = 0; i < ops; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				if (known_count > 0 && $urandom_range(0, 3) == 0) begin
					k = $urandom_range(0, known_count - 1);
					send_item(REQ_QUERY, known_x[k], known_y[k]);
				end else begin
					send_item(REQ_QUERY, near_coord(cx, span), near_coord(cy, span));
				end
			end else if (pick < 84) begin
				send_item(REQ_APPEND, near_coord(cx, span), near_coord(cy, span));
			end else if (pick < 90) begin
				send_item(REQ_UNUSED, COORD_W'($urandom), COORD_W'($urandom));
			end else if (pick < 94) begin
				send_item(REQ_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
			end else begin
				send_item(REQ_QUERY, COORD_W'($urandom), COORD_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With the reset radius of zero nothing can match, and a
		// query on an empty table still answers.
		send_item(REQ_QUERY, 16'sd100, -16'sd100);
		send_item(REQ_UNUSED, -16'sd1, -16'sd1);
		send_item(REQ_APPEND, 16'sd0, 16'sd0);
		send_item(REQ_QUERY, 16'sd0, 16'sd0);

		// Three points all at a squared distance of 25 from the query: equal to
		// the radius misses, just above it picks the lowest index.
		write_radius(RADIUS_W'(25));
		send_item(REQ_APPEND, 16'sd6, 16'sd8);
		send_item(REQ_APPEND, 16'sd0, 16'sd0);
		send_item(REQ_QUERY, 16'sd3, 16'sd4);
		write_radius(RADIUS_W'(26));
		send_item(REQ_QUERY, 16'sd3, 16'sd4);
		send_item(REQ_QUERY, 16'sd6, 16'sd8);
		send_item(REQ_QUERY, 16'sd7, 16'sd8);

		// Coordinate extremes with the widest radius.
		write_radius(RADIUS_MAX);
		send_item(REQ_APPEND, -16'sd32768, -16'sd32768);
		send_item(REQ_APPEND, 16'sd32767, 16'sd32767);
		send_item(REQ_QUERY, 16'sd32767, -16'sd32768);
		send_item(REQ_QUERY, -16'sd32768, -16'sd32768);
		send_item(REQ_CLEAR, 16'sd0, 16'sd0);
		send_item(REQ_QUERY, 16'sd0, 16'sd0);
		send_item(REQ_APPEND, -16'sd32768, 16'sd32767);
		send_item(REQ_QUERY, 16'sd32767, -16'sd32768);

		// The largest possible distance, first equal to the radius, then below it.
		write_radius(RADIUS_W'(64'd8589672450));
		send_item(REQ_QUERY, 16'sd32767, -16'sd32768);
		write_radius(RADIUS_W'(64'd8589672451));
		send_item(REQ_QUERY, 16'sd32767, -16'sd32768);

		// Full table: dropped appends and the highest index.
		fill_table();

		counted_items = 0;
		while (counted_items < RANDOM_ITEMS)
			random_phase();

		// Drain the remaining answers and give the block time to misbehave.
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
